/* rtl/core/tcfs_pkg.sv */
// Package for the tilt complementary filter servo block.
// Holds fixed constants and the CORDIC arctangent table; no dependencies.
package tcfs_pkg;
    localparam int unsigned ATAN_DEPTH = 24;
    localparam logic signed [31:0] PI_U26 = 32'sd210828714;
    localparam logic [16:0] INV_PI_Q16X4 = 17'd83443;
    localparam logic [15:0] CENTRE_WIDTH = 16'd16384;
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd1311;
    localparam logic [15:0] RST_FILTER_GAIN = 16'd12288;
    localparam logic [14:0] RST_ANGLE_LIMIT = 15'd12868;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] REG_FILTER_GAIN = 2'd1;
    localparam logic [1:0] REG_ANGLE_LIMIT = 2'd2;

    function automatic logic [25:0] atan_entry(input logic [4:0] idx);
        logic [25:0] v;
        case (idx)
            5'd0:  v = 26'd52707179;
            5'd1:  v = 26'd31114864;
            5'd2:  v = 26'd16440240;
            5'd3:  v = 26'd8345322;
            5'd4:  v = 26'd4188855;
            5'd5:  v = 26'd2096470;
            5'd6:  v = 26'd1048491;
            5'd7:  v = 26'd524277;
            5'd8:  v = 26'd262143;
            5'd9:  v = 26'd131072;
            5'd10: v = 26'd65536;
            5'd11: v = 26'd32768;
            5'd12: v = 26'd16384;
            5'd13: v = 26'd8192;
            5'd14: v = 26'd4096;
            5'd15: v = 26'd2048;
            5'd16: v = 26'd1024;
            5'd17: v = 26'd512;
            5'd18: v = 26'd256;
            5'd19: v = 26'd128;
            5'd20: v = 26'd64;
            5'd21: v = 26'd32;
            5'd22: v = 26'd16;
            5'd23: v = 26'd8;
            default: v = 26'd0;
        endcase
        return v;
    endfunction
endpackage

/* rtl/core/tilt_complementary_filter_servo.sv */
// Tilt complementary filter servo: CORDIC roll/pitch, complementary filter, servo widths.
// A new input is taken only in idle, once the previous result has been accepted; the block
// runs the shared CORDIC twice (roll, then pitch), then the shared multiplier in sequence
// for each axis, then a width stage.
// Reset (synchronous, active low): estimates zero, widths centred, registers at defaults.
// Depends on tcfs_pkg and tcfs_cordic.
module tilt_complementary_filter_servo #(
    parameter int CORDIC_STEPS = 16,
    parameter int ESTIMATE_FRAC_BITS = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_roll_rate,
    input  logic signed [15:0] i_gyro_pitch_rate,
    input  logic               i_drive_enable,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic [15:0]        o_roll_width,
    output logic [15:0]        o_pitch_width
);
    localparam int F = ESTIMATE_FRAC_BITS;
    localparam int EW = F + 3;      // estimate width
    localparam int SW = F + 32;     // sum width, ample headroom
    localparam int AW = F + 11;     // multiplier operand: covers error and rate

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CROLL = 10'b0000000010,
        S_WROLL = 10'b0000000100,
        S_CPIT  = 10'b0000001000,
        S_WPIT  = 10'b0000010000,
        S_KP    = 10'b0000100000,
        S_TS    = 10'b0001000000,
        S_UPD   = 10'b0010000000,
        S_WID   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_ts, r_kp;
    logic [14:0] r_lim;
    logic signed [15:0] r_ax, r_ay, r_az, r_gr, r_gp;
    logic r_en, r_pend, r_axis;
    logic signed [15:0] r_acc_roll, r_acc_pitch;
    logic signed [EW-1:0] r_est_roll, r_est_pitch;
    logic [15:0] r_w_roll, r_w_pitch;
    logic signed [SW-1:0] r_prod;
    logic signed [15:0] r_q_roll, r_q_pitch;

    // CORDIC
    logic cor_start, cor_done;
    logic signed [16:0] cor_y, cor_x;
    logic signed [15:0] cor_ang;
    assign cor_start = (r_state == S_CROLL) || (r_state == S_CPIT);
    assign cor_x = 17'(r_az);
    assign cor_y = (r_state == S_CPIT) ? -17'(r_ax) : 17'(r_ay);

    tcfs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_y(cor_y), .i_x(cor_x), .o_done(cor_done), .o_angle(cor_ang)
    );

    // Shared multiplier: operand a (error or rate) times b (17-bit signed gain or period).
    logic signed [EW-1:0] cur_est;
    logic signed [15:0] cur_acc, cur_gyro;
    logic signed [EW+1:0] err;
    logic signed [AW-1:0] mul_a;
    logic signed [AW+16:0] mul_p;
    logic signed [SW-1:0] mul_o, sum, rate_r, delta;
    logic signed [16:0] mul_b;
    logic signed [SW-1:0] nxt;
    logic signed [SW-1:0] lim_hi, lim_lo;
    logic signed [EW-1:0] est_new;
    logic signed [SW-1:0] q_full;
    logic signed [15:0] q_sat;

    assign cur_est  = r_axis ? r_est_pitch : r_est_roll;
    assign cur_acc  = r_axis ? r_acc_pitch : r_acc_roll;
    assign cur_gyro = r_axis ? r_gp : r_gr;
    assign err = (EW+2)'(cur_acc) * (EW+2)'(2 ** (F - 13)) - (EW+2)'(cur_est);
    assign sum = (SW'(cur_gyro) <<< F) + r_prod;
    assign rate_r = (sum + (SW'(1) <<< 11)) >>> 12;
    assign mul_a = (r_state == S_KP) ? AW'(err) : AW'(rate_r);
    assign mul_b = (r_state == S_KP) ? signed'({1'b0, r_kp}) : signed'({1'b0, r_ts});
    assign mul_p = mul_a * mul_b;
    assign mul_o = SW'(mul_p);
    assign delta = (r_prod + (SW'(1) <<< 15)) >>> 16;
    assign nxt = SW'(cur_est) + delta;
    assign lim_hi = (SW'(1) <<< (F + 2)) - SW'(1);
    assign lim_lo = -(SW'(1) <<< (F + 2));
    assign est_new = (nxt > lim_hi) ? EW'(lim_hi) : (nxt < lim_lo) ? EW'(lim_lo) : EW'(nxt);
    assign q_full = (SW'(est_new) + (SW'(1) <<< (F - 14))) >>> (F - 13);
    assign q_sat = (q_full > 32767) ? 16'sh7FFF : (q_full < -32768) ? 16'sh8000 : q_full[15:0];

    function automatic logic [15:0] width_of(input logic signed [15:0] a,
                                             input logic [14:0] lim,
                                             input logic [15:0] old);
        logic signed [16:0] mag;
        logic signed [34:0] p;
        logic signed [34:0] w;
        mag = (a < 0) ? -17'(a) : 17'(a);
        p = 35'(a) * 35'(signed'({1'b0, tcfs_pkg::INV_PI_Q16X4}));
        w = signed'(35'(tcfs_pkg::CENTRE_WIDTH)) + ((p + 35'sd32768) >>> 16);
        if (mag > 17'(signed'({2'b0, lim}))) return old;
        if (w < 0) return 16'd0;
        if (w > 65535) return 16'hFFFF;
        return w[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ts <= tcfs_pkg::RST_SAMPLE_PERIOD;
            r_kp <= tcfs_pkg::RST_FILTER_GAIN;
            r_lim <= tcfs_pkg::RST_ANGLE_LIMIT;
            r_est_roll <= '0;
            r_est_pitch <= '0;
            r_w_roll <= tcfs_pkg::CENTRE_WIDTH;
            r_w_pitch <= tcfs_pkg::CENTRE_WIDTH;
            r_pend <= 1'b0;
            r_axis <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcfs_pkg::REG_SAMPLE_PERIOD: r_ts <= i_cfg_data;
                    tcfs_pkg::REG_FILTER_GAIN:   r_kp <= i_cfg_data;
                    tcfs_pkg::REG_ANGLE_LIMIT:   r_lim <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ax <= i_accel_x; r_ay <= i_accel_y; r_az <= i_accel_z;
                        r_gr <= i_gyro_roll_rate; r_gp <= i_gyro_pitch_rate;
                        r_en <= i_drive_enable;
                        r_state <= S_CROLL;
                    end
                end
                S_CROLL: r_state <= S_WROLL;
                S_WROLL: if (cor_done) begin
                    r_acc_roll <= cor_ang;
                    r_state <= S_CPIT;
                end
                S_CPIT: r_state <= S_WPIT;
                S_WPIT: if (cor_done) begin
                    r_acc_pitch <= cor_ang;
                    r_axis <= 1'b0;
                    r_state <= S_KP;
                end
                S_KP: begin
                    r_prod <= mul_o;
                    r_state <= S_TS;
                end
                S_TS: begin
                    r_prod <= mul_o;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // commit one axis, then run the other
                    if (!r_axis) begin
                        r_est_roll <= est_new;
                        r_q_roll <= q_sat;
                        r_axis <= 1'b1;
                        r_state <= S_KP;
                    end else begin
                        r_est_pitch <= est_new;
                        r_q_pitch <= q_sat;
                        r_state <= S_WID;
                    end
                end
                S_WID: begin
                    // map both registered angles to widths, or recentre once on disable
                    if (r_en) begin
                        r_pend <= 1'b1;
                        r_w_roll <= width_of(r_q_roll, r_lim, r_w_roll);
                        r_w_pitch <= width_of(r_q_pitch, r_lim, r_w_pitch);
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                        r_w_roll <= tcfs_pkg::CENTRE_WIDTH;
                        r_w_pitch <= tcfs_pkg::CENTRE_WIDTH;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_roll_angle = r_q_roll;
    assign o_pitch_angle = r_q_pitch;
    assign o_roll_width = r_w_roll;
    assign o_pitch_width = r_w_pitch;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and valid together");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_roll_angle))
        else $error("result changed while stalled");
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_en) |-> r_pend)
        else $error("pending flag lost");
`endif
endmodule

/* rtl/core/tcfs_cordic.sv */
// Iterative vectoring CORDIC: atan2(y, x) as Q2.13 radians, one step a cycle.
// Depends on tcfs_pkg.
module tcfs_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_y,
    input  logic signed [16:0] i_x,
    output logic               o_done,
    output logic signed [15:0] o_angle
);
    localparam int DEPTH = int'(tcfs_pkg::ATAN_DEPTH);
    localparam int NSTEP = (STEPS < DEPTH) ? STEPS : DEPTH;
    localparam int CW = $clog2(NSTEP + 1);

    logic signed [35:0] r_x, r_y, n_x, n_y;
    logic signed [31:0] r_z, n_z;
    logic [CW-1:0] r_cnt;
    logic r_busy, r_done;
    logic signed [35:0] sh_x, sh_y;
    logic signed [31:0] tab;
    logic signed [31:0] zr;

    assign sh_x = r_x >>> r_cnt;
    assign sh_y = r_y >>> r_cnt;
    assign tab = 32'(signed'({1'b0, tcfs_pkg::atan_entry(5'(r_cnt))}));

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (r_y > 0) begin
            n_x = r_x + sh_y;
            n_y = r_y - sh_x;
            n_z = r_z + tab;
        end else if (r_y < 0) begin
            n_x = r_x - sh_y;
            n_y = r_y + sh_x;
            n_z = r_z - tab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                if (i_x < 0) begin
                    r_z <= (i_y >= 0) ? tcfs_pkg::PI_U26 : -tcfs_pkg::PI_U26;
                    r_x <= 36'(-i_x) <<< 16;
                    r_y <= 36'(-i_y) <<< 16;
                end else begin
                    r_z <= '0;
                    r_x <= 36'(i_x) <<< 16;
                    r_y <= 36'(i_y) <<< 16;
                end
            end else if (r_busy) begin
                if (r_cnt == CW'(NSTEP)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign zr = (r_z + 32'sd4096) >>> 13;
    assign o_angle = zr[15:0];
    assign o_done = r_done;
endmodule

/* sim/testbench.sv */
// Self-checking testbench for tilt_complementary_filter_servo.
// Drives IMU samples with random gaps and output stalls, predicts every
// result in-line; depends on tcfs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
    localparam int STEPS = 16;
    localparam int EFB = 21;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gr;
        logic signed [15:0] gp;
        logic               en;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [15:0]        rw;
        logic [15:0]        pw;
    } t_servo_out;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_accel_x, i_accel_y, i_accel_z;
    logic signed [15:0] i_gyro_roll_rate, i_gyro_pitch_rate;
    logic               i_drive_enable;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_roll_angle, o_pitch_angle;
    logic [15:0]        o_roll_width, o_pitch_width;

    tilt_complementary_filter_servo dut (.*);

    // Predictor state: its own copy of registers and filter state.
    longint m_period, m_gain, m_limit;
    longint m_roll_est, m_pitch_est;
    longint m_roll_w, m_pitch_w;
    bit     m_recentre;

    t_sample    pending_samples[$];
    t_servo_out expected_outputs[$];
    int  error_count;
    int  sent_count, seen_count;
    bit  quiet_phase;
    bit  stim_done;
    int  idle_cycles;
    int  send_gap;
    int  stall_left;
    bit  o_ready_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan2_q13(longint y, longint x);
        longint z, nx;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(tcfs_pkg::PI_U26) : -longint'(tcfs_pkg::PI_U26);
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < STEPS && i < int'(tcfs_pkg::ATAN_DEPTH); i++) begin
            if (y > 0) begin
                nx = x + shr_floor(y, i);
                y  = y - shr_floor(x, i);
                x  = nx;
                z += longint'(tcfs_pkg::atan_entry(5'(i)));
            end else if (y < 0) begin
                nx = x - shr_floor(y, i);
                y  = y + shr_floor(x, i);
                x  = nx;
                z -= longint'(tcfs_pkg::atan_entry(5'(i)));
            end
        end
        return round_half_up(z, 13);
    endfunction

    function automatic longint filter_step(longint est, longint acc_q13, longint gyro);
        longint lim, err, sum, rate, delta;
        lim   = longint'(1) << (EFB + 2);
        err   = acc_q13 * (longint'(1) << (EFB - 13)) - est;
        sum   = gyro * (longint'(1) << EFB) + m_gain * err;
        rate  = round_half_up(sum, 12);
        delta = round_half_up(rate * m_period, 16);
        return clip(est + delta, -lim, lim - 1);
    endfunction

    function automatic longint width_for(longint ang, longint old);
        longint a;
        a = ang < 0 ? -ang : ang;
        if (a > m_limit) return old;
        return clip(longint'(tcfs_pkg::CENTRE_WIDTH)
                    + round_half_up(ang * longint'(tcfs_pkg::INV_PI_Q16X4), 16), 0, 65535);
    endfunction

    // Advance the predictor by one accepted sample and queue its result.
    task automatic predict_servo(input t_sample s);
        longint rq, pq;
        t_servo_out r;
        m_roll_est  = filter_step(m_roll_est, atan2_q13(s.ay, s.az), s.gr);
        m_pitch_est = filter_step(m_pitch_est, atan2_q13(-longint'(s.ax), s.az), s.gp);
        rq = clip(round_half_up(m_roll_est, EFB - 13), -32768, 32767);
        pq = clip(round_half_up(m_pitch_est, EFB - 13), -32768, 32767);
        if (s.en) begin
            m_recentre = 1'b1;
            m_roll_w  = width_for(rq, m_roll_w);
            m_pitch_w = width_for(pq, m_pitch_w);
        end else if (m_recentre) begin
            m_recentre = 1'b0;
            m_roll_w  = tcfs_pkg::CENTRE_WIDTH;
            m_pitch_w = tcfs_pkg::CENTRE_WIDTH;
        end
        r.roll  = 16'(rq);
        r.pitch = 16'(pq);
        r.rw    = 16'(m_roll_w);
        r.pw    = 16'(m_pitch_w);
        expected_outputs.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch on result %0d: %s got %0d want %0d", seen_count, what, got, want);
    endtask

    // Driver: present the next pending sample, hold it until the transfer.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    t_sample s;
                    s = pending_samples.pop_front();
                    i_accel_x         <= s.ax;
                    i_accel_y         <= s.ay;
                    i_accel_z         <= s.az;
                    i_gyro_roll_rate  <= s.gr;
                    i_gyro_pitch_rate <= s.gp;
                    i_drive_enable    <= s.en;
                    i_valid <= 1'b1;
                    if (!quiet_phase && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            // Receiver stalls in bursts.
            if (quiet_phase) begin
                i_ready <= 1'b1;
                stall_left <= 0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 14);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input transfers, check on output transfers.
    always @(posedge i_clk) begin
        logic in_xfer, out_xfer;
        in_xfer  = i_valid && o_ready;
        out_xfer = o_valid && i_ready;
        if (!i_rst_n) begin
            o_ready_seen <= 1'b0;
        end else begin
            o_ready_seen <= in_xfer;
            idle_cycles <= (in_xfer || out_xfer) ? 0 : idle_cycles + 1;
            if (in_xfer) begin
                t_sample s;
                s = '{i_accel_x, i_accel_y, i_accel_z, i_gyro_roll_rate,
                      i_gyro_pitch_rate, i_drive_enable};
                predict_servo(s);
                sent_count <= sent_count + 1;
            end
            if (out_xfer) begin
                seen_count <= seen_count + 1;
                if (expected_outputs.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    t_servo_out w;
                    w = expected_outputs.pop_front();
                    if (o_roll_angle !== w.roll)
                        report_mismatch("roll_angle", o_roll_angle, w.roll);
                    if (o_pitch_angle !== w.pitch)
                        report_mismatch("pitch_angle", o_pitch_angle, w.pitch);
                    if (o_roll_width !== w.rw)
                        report_mismatch("roll_width", o_roll_width, w.rw);
                    if (o_pitch_width !== w.pw)
                        report_mismatch("pitch_width", o_pitch_width, w.pw);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    function automatic t_sample random_sample();
        t_sample s;
        int shape;
        logic [95:0] raw;
        shape = $urandom_range(0, 9);
        raw = {$urandom, $urandom, $urandom};
        s = raw[$bits(t_sample)-1:0];
        if (shape < 6) begin
            // gravity-like tilt with small rates: keeps accelerometer angles inside the reset-default limit
            s.ax = 16'($signed($urandom_range(0, 16000)) - 8000);
            s.ay = 16'($signed($urandom_range(0, 16000)) - 8000);
            s.az = 16'($urandom_range(4000, 16000));
            s.gr = 16'($signed($urandom_range(0, 4000)) - 2000);
            s.gp = 16'($signed($urandom_range(0, 4000)) - 2000);
        end else if (shape == 6) begin
            s.ay = 0;
            s.ax = 0;
        end
        s.en = ($urandom_range(0, 3) != 0);
        return s;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tcfs_pkg::REG_SAMPLE_PERIOD: m_period = val;
            tcfs_pkg::REG_FILTER_GAIN:   m_gain = val;
            tcfs_pkg::REG_ANGLE_LIMIT:   m_limit = val[14:0];
            default: ;
        endcase
    endtask

    // Wait for every result, then let the block settle before a register write.
    task automatic drain();
        while (pending_samples.size() > 0 || i_valid || expected_outputs.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++) pending_samples.push_back(random_sample());
    endtask

    function automatic t_sample mk(int ax, int ay, int az, int gr, int gp, bit en);
        t_sample s;
        s = '{16'(ax), 16'(ay), 16'(az), 16'(gr), 16'(gp), en};
        return s;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = tcfs_pkg::REG_SAMPLE_PERIOD;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_accel_x = '0; i_accel_y = '0; i_accel_z = '0;
        i_gyro_roll_rate = '0; i_gyro_pitch_rate = '0;
        i_drive_enable = 1'b0;
        m_period = tcfs_pkg::RST_SAMPLE_PERIOD;
        m_gain = tcfs_pkg::RST_FILTER_GAIN;
        m_limit = tcfs_pkg::RST_ANGLE_LIMIT;
        m_roll_est = 0; m_pitch_est = 0;
        m_roll_w = tcfs_pkg::CENTRE_WIDTH; m_pitch_w = tcfs_pkg::CENTRE_WIDTH;
        m_recentre = 1'b0;
        error_count = 0; sent_count = 0; seen_count = 0;
        quiet_phase = 1'b0; stim_done = 1'b0;
        idle_cycles = 0; send_gap = 0; stall_left = 0; o_ready_seen = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero vector, negative x with zero y, field extremes, recentre.
        pending_samples.push_back(mk(0, 0, 0, 0, 0, 1));
        pending_samples.push_back(mk(0, 0, -100, 0, 0, 1));
        pending_samples.push_back(mk(0, 0, -100, 0, 0, 0));
        pending_samples.push_back(mk(32767, -32768, -32768, 32767, -32768, 1));
        pending_samples.push_back(mk(-32768, 32767, 32767, -32768, 32767, 1));
        pending_samples.push_back(mk(-32768, 32767, 32767, 32767, 32767, 1));
        pending_samples.push_back(mk(-1, -1, -1, -1, -1, 0));
        pending_samples.push_back(mk(0, 5000, 16000, 0, 0, 1));
        pending_samples.push_back(mk(3000, 0, 16000, 100, -100, 1));
        pending_samples.push_back(mk(0, 0, 16000, 0, 0, 0));
        pending_samples.push_back(mk(0, 0, 16000, 0, 0, 0));
        pending_samples.push_back(mk(0, -1, 0, 0, 0, 1));
        pending_samples.push_back(mk(32767, 0, 0, -32768, -32768, 1));
        push_random(150);
        drain();

        // Extremes of every register.
        write_reg(tcfs_pkg::REG_SAMPLE_PERIOD, 16'd65535);
        write_reg(tcfs_pkg::REG_FILTER_GAIN, 16'd65535);
        write_reg(tcfs_pkg::REG_ANGLE_LIMIT, 16'd32767);
        push_random(120);
        drain();
        write_reg(tcfs_pkg::REG_SAMPLE_PERIOD, 16'd0);
        write_reg(tcfs_pkg::REG_FILTER_GAIN, 16'd1);
        write_reg(tcfs_pkg::REG_ANGLE_LIMIT, 16'd0);
        push_random(100);
        drain();
        write_reg(tcfs_pkg::REG_SAMPLE_PERIOD, 16'd1);
        write_reg(tcfs_pkg::REG_ANGLE_LIMIT, 16'd25736);
        push_random(100);
        drain();
        write_reg(tcfs_pkg::REG_SAMPLE_PERIOD, 16'($urandom_range(200, 8000)));
        write_reg(tcfs_pkg::REG_FILTER_GAIN, 16'($urandom_range(1000, 40000)));
        write_reg(tcfs_pkg::REG_ANGLE_LIMIT, 16'($urandom_range(2000, 20000)));
        push_random(200);
        drain();

        // Last stretch runs with no idling on either side.
        quiet_phase = 1'b1;
        write_reg(tcfs_pkg::REG_SAMPLE_PERIOD, tcfs_pkg::RST_SAMPLE_PERIOD);
        write_reg(tcfs_pkg::REG_FILTER_GAIN, tcfs_pkg::RST_FILTER_GAIN);
        write_reg(tcfs_pkg::REG_ANGLE_LIMIT, 16'(tcfs_pkg::RST_ANGLE_LIMIT));
        push_random(150);
        drain();

        $display("covered %0d samples and %0d results over six register settings",
                 sent_count, seen_count);
        $display("including zero vectors, negative-z flips and recentre on disable");
        if (error_count == 0 && expected_outputs.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
